@@ design/lsc_pkg.sv @@
`timescale 1ns / 1ps
package lsc_pkg;

  localparam int CW = 12;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
  } seg_in_t;

  typedef struct packed {
    logic                 visible;
    logic signed [CW-1:0] clip_start_x;
    logic signed [CW-1:0] clip_start_y;
    logic signed [CW-1:0] clip_end_x;
    logic signed [CW-1:0] clip_end_y;
  } seg_out_t;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_TOP    = 2'd2;
  localparam logic [1:0] REG_BOTTOM = 2'd3;

endpackage

@@ design/line_segment_clipper.sv @@
`timescale 1ns / 1ps
// Stages: two setup stages, one restoring divider stage per quotient bit and five
// stages for the ratios, bounds, products, sums and output register.
// Throughput: one segment per cycle; a stalled result holds the whole pipeline.
// Reset: synchronous active-low rst_n clears all valid bits and loads the
// default window (100, 300, 100, 300).
module line_segment_clipper #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lsc_pkg::seg_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lsc_pkg::seg_out_t            out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [lsc_pkg::CW-1:0]       cfg_data
);

  localparam int CW  = lsc_pkg::CW;
  localparam int DW  = CW + 2;
  localparam int NW  = DW + FRAC_BITS;
  localparam int UW  = FRAC_BITS + 2;
  localparam int PW  = DW + UW;
  localparam int QS  = NW;
  localparam int NS  = 2 + QS + 5;

  logic signed [CW-1:0] wl_r, wr_r, wt_r, wb_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= CW'(100);
      wr_r <= CW'(300);
      wt_r <= CW'(100);
      wb_r <= CW'(300);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lsc_pkg::REG_LEFT:   wl_r <= cfg_data;
        lsc_pkg::REG_RIGHT:  wr_r <= cfg_data;
        lsc_pkg::REG_TOP:    wt_r <= cfg_data;
        lsc_pkg::REG_BOTTOM: wb_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  logic [NS-1:0] v_r;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NS-2:0], in_valid};
  end

  // Stage A: edge terms.
  logic signed [DW-1:0] x1_a, y1_a, dx_a, dy_a;
  logic signed [DW-1:0] p_a [4];
  logic signed [DW-1:0] q_a [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      x1_a  <= DW'(in_data.start_x);
      y1_a  <= DW'(in_data.start_y);
      dx_a  <= DW'(in_data.end_x) - DW'(in_data.start_x);
      dy_a  <= DW'(in_data.end_y) - DW'(in_data.start_y);
      q_a[0] <= DW'(in_data.start_x) - DW'(wl_r);
      q_a[1] <= DW'(wr_r) - DW'(in_data.start_x);
      q_a[2] <= DW'(in_data.start_y) - DW'(wt_r);
      q_a[3] <= DW'(wb_r) - DW'(in_data.start_y);
    end
  end
  always_comb begin
    p_a[0] = -dx_a;
    p_a[1] = dx_a;
    p_a[2] = -dy_a;
    p_a[3] = dy_a;
  end

  // Stage B loads magnitudes and signs; the edge divider pipeline behind it
  // resolves one quotient bit per stage.
  logic [NW-1:0] dn_r [4][QS+1];
  logic [NW-1:0] dq_r [4][QS+1];
  logic [DW-1:0] dd_r [4][QS+1];
  logic [NW:0]   dr_r [4][QS+1];
  logic [3:0] dneg_r [QS+1];
  logic [3:0] dpz_r  [QS+1];
  logic [3:0] dpn_r  [QS+1];
  logic [3:0] drej_r [QS+1];
  logic signed [DW-1:0] dx1_r [QS+1], dy1_r [QS+1], ddx_r [QS+1], ddy_r [QS+1];

  always_ff @(posedge clk) begin
    logic [NW:0] t;
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        dn_r[i][0] <= {(q_a[i][DW-1] ? -q_a[i] : q_a[i]), {FRAC_BITS{1'b0}}};
        dq_r[i][0] <= '0;
        dd_r[i][0] <= p_a[i][DW-1] ? -p_a[i] : p_a[i];
        dr_r[i][0] <= '0;
        dneg_r[0][i] <= q_a[i][DW-1] ^ p_a[i][DW-1];
        dpz_r[0][i]  <= p_a[i] == '0;
        dpn_r[0][i]  <= p_a[i][DW-1];
        drej_r[0][i] <= (p_a[i] == '0) && q_a[i][DW-1];
      end
      dx1_r[0] <= x1_a; dy1_r[0] <= y1_a; ddx_r[0] <= dx_a; ddy_r[0] <= dy_a;
      for (int s = 0; s < QS; s++) begin
        for (int i = 0; i < 4; i++) begin
          t = {dr_r[i][s][NW-1:0], dn_r[i][s][NW-1]};
          if (t >= {{(NW+1-DW){1'b0}}, dd_r[i][s]}) begin
            dr_r[i][s+1] <= t - {{(NW+1-DW){1'b0}}, dd_r[i][s]};
            dq_r[i][s+1] <= {dq_r[i][s][NW-2:0], 1'b1};
          end else begin
            dr_r[i][s+1] <= t;
            dq_r[i][s+1] <= {dq_r[i][s][NW-2:0], 1'b0};
          end
          dn_r[i][s+1] <= {dn_r[i][s][NW-2:0], 1'b0};
          dd_r[i][s+1] <= dd_r[i][s];
        end
        dneg_r[s+1] <= dneg_r[s]; dpz_r[s+1] <= dpz_r[s];
        dpn_r[s+1] <= dpn_r[s]; drej_r[s+1] <= drej_r[s];
        dx1_r[s+1] <= dx1_r[s]; dy1_r[s+1] <= dy1_r[s];
        ddx_r[s+1] <= ddx_r[s]; ddy_r[s+1] <= ddy_r[s];
      end
    end
  end

  // Stage C: signed ratios, entering max and leaving min in two levels.
  logic signed [NW:0] r_c [4];
  logic [3:0] pz_c, pn_c;
  logic rej_c;
  logic signed [DW-1:0] x1_c, y1_c, dx_c, dy_c;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        r_c[i] <= dneg_r[QS][i] ? -$signed({1'b0, dq_r[i][QS]})
                                : $signed({1'b0, dq_r[i][QS]});
      end
      pz_c <= dpz_r[QS]; pn_c <= dpn_r[QS]; rej_c <= |drej_r[QS];
      x1_c <= dx1_r[QS]; y1_c <= dy1_r[QS]; dx_c <= ddx_r[QS]; dy_c <= ddy_r[QS];
    end
  end

  localparam logic signed [NW:0] U1 = (NW+1)'(1) <<< FRAC_BITS;
  logic signed [NW:0] ue_d, ux_d;
  logic rej_d;
  logic signed [DW-1:0] x1_d, y1_d, dx_d, dy_d;
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [NW:0] e, x;
      e = '0;
      x = U1;
      for (int i = 0; i < 4; i++) begin
        if (!pz_c[i]) begin
          if (pn_c[i]) begin
            if (r_c[i] > e) e = r_c[i];
          end else if (r_c[i] < x) x = r_c[i];
        end
      end
      ue_d <= e; ux_d <= x;
      rej_d <= rej_c || (e > x);
      x1_d <= x1_c; y1_d <= y1_c; dx_d <= dx_c; dy_d <= dy_c;
    end
  end

  // Stage E: products d*u, u fits in [0,1] so UW bits suffice.
  logic signed [PW-1:0] pr_e [4];
  logic signed [DW-1:0] c0_e [4];
  logic rej_e;
  always_ff @(posedge clk) begin
    if (adv) begin
      pr_e[0] <= PW'(dx_d) * PW'(ue_d[UW-1:0]);
      pr_e[1] <= PW'(dy_d) * PW'(ue_d[UW-1:0]);
      pr_e[2] <= PW'(dx_d) * PW'(ux_d[UW-1:0]);
      pr_e[3] <= PW'(dy_d) * PW'(ux_d[UW-1:0]);
      c0_e[0] <= x1_d; c0_e[1] <= y1_d; c0_e[2] <= x1_d; c0_e[3] <= y1_d;
      rej_e <= rej_d;
    end
  end

  // Stage F: c0*2^F + d*u, then truncating shift toward zero.
  logic signed [PW:0] s_f [4];
  logic rej_f;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        s_f[i] <= ((PW+1)'(c0_e[i]) <<< FRAC_BITS) + (PW+1)'(pr_e[i]);
      end
      rej_f <= rej_e;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [PW:0] a, t;
      out_data.visible <= !rej_f;
      for (int i = 0; i < 4; i++) begin
        a = s_f[i];
        t = (a + (a[PW] ? (PW+1)'((1 << FRAC_BITS) - 1) : '0)) >>> FRAC_BITS;
        if (rej_f) t = '0;
        unique case (i)
          0: out_data.clip_start_x <= t[CW-1:0];
          1: out_data.clip_start_y <= t[CW-1:0];
          2: out_data.clip_end_x   <= t[CW-1:0];
          default: out_data.clip_end_y <= t[CW-1:0];
        endcase
      end
    end
  end

endmodule
